>>> rtl/scv_pkg.sv
`timescale 1ns / 1ps

package scv_pkg;

   // Field widths fixed by the interface
   localparam int SAMPLE_W     = 16;
   localparam int CNT_FIELD_W  = 24;
   localparam int THRESH_W     = 38;
   localparam int ENERGY_W     = 39;
   localparam int SQUARE_W     = 31;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 38;

   localparam int REQ_TDATA_W  = 32;
   localparam int REQ_TUSER_W  = 1;
   localparam int RSP_TDATA_W  = 64;
   localparam int RSP_TUSER_W  = 4;

   // Saturation limits of the mono sum
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

   // Default parameter values
   localparam int CHUNK_LEN_DEFAULT  = 256;
   localparam int COUNT_BITS_DEFAULT = 24;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_ENERGY_THRESHOLD = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SILENCE_TIMEOUT  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_NO_SPEECH_TIMEOUT = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_RECORD       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_TRAIL_PAD        = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_BUFFER_CAPACITY  = 3'd5;

   // Register reset values
   localparam logic [THRESH_W-1:0]    RST_ENERGY_THRESHOLD  = '0;
   localparam logic [CNT_FIELD_W-1:0] RST_SILENCE_TIMEOUT   = 24'd16000;
   localparam logic [CNT_FIELD_W-1:0] RST_NO_SPEECH_TIMEOUT = 24'd80000;
   localparam logic [CNT_FIELD_W-1:0] RST_MAX_RECORD        = 24'd160000;
   localparam logic [CNT_FIELD_W-1:0] RST_TRAIL_PAD         = 24'd3200;
   localparam logic [CNT_FIELD_W-1:0] RST_BUFFER_CAPACITY   = 24'd160000;

   typedef struct packed {
      logic [THRESH_W-1:0]    energy_threshold;
      logic [CNT_FIELD_W-1:0] silence_timeout;
      logic [CNT_FIELD_W-1:0] no_speech_timeout;
      logic [CNT_FIELD_W-1:0] max_record;
      logic [CNT_FIELD_W-1:0] trail_pad;
      logic [CNT_FIELD_W-1:0] buffer_capacity;
   } scv_cfg_type;

   typedef struct packed {
      logic                       begin_capture;
      logic signed [SAMPLE_W-1:0] mono_sample;
      logic [SQUARE_W-1:0]        square;
   } scv_frame_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] mono_sample;
      logic                       store_enable;
      logic [CNT_FIELD_W-1:0]     store_index;
      logic                       chunk_end;
      logic                       chunk_loud;
      logic                       capture_done;
      logic                       speech_found;
      logic [CNT_FIELD_W-1:0]     kept_length;
   } scv_result_type;

endpackage

>>> rtl/scv_csr.sv
`timescale 1ns / 1ps

module scv_csr import scv_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output scv_cfg_type            cfg
);

   scv_cfg_type cfg_ff;
   scv_cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_ENERGY_THRESHOLD:  cfg_in.energy_threshold  = csr_data[THRESH_W-1:0];
            REG_SILENCE_TIMEOUT:   cfg_in.silence_timeout   = csr_data[CNT_FIELD_W-1:0];
            REG_NO_SPEECH_TIMEOUT: cfg_in.no_speech_timeout = csr_data[CNT_FIELD_W-1:0];
            REG_MAX_RECORD:        cfg_in.max_record        = csr_data[CNT_FIELD_W-1:0];
            REG_TRAIL_PAD:         cfg_in.trail_pad         = csr_data[CNT_FIELD_W-1:0];
            REG_BUFFER_CAPACITY:   cfg_in.buffer_capacity   = csr_data[CNT_FIELD_W-1:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.energy_threshold  <= RST_ENERGY_THRESHOLD;
         cfg_ff.silence_timeout   <= RST_SILENCE_TIMEOUT;
         cfg_ff.no_speech_timeout <= RST_NO_SPEECH_TIMEOUT;
         cfg_ff.max_record        <= RST_MAX_RECORD;
         cfg_ff.trail_pad         <= RST_TRAIL_PAD;
         cfg_ff.buffer_capacity   <= RST_BUFFER_CAPACITY;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> rtl/scv_front.sv
`timescale 1ns / 1ps

module scv_front import scv_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic                       begin_capture,
   input  logic signed [SAMPLE_W-1:0] left_sample,
   input  logic signed [SAMPLE_W-1:0] right_sample,
   output logic                       out_valid,
   input  logic                       out_ready,
   output scv_frame_type              out_frame
);

   logic                       valid_ff;
   logic                       valid_in;
   scv_frame_type              frame_ff;
   scv_frame_type              frame_in;
   logic signed [SAMPLE_W:0]   sum_wide;
   logic signed [SAMPLE_W-1:0] mono;
   logic signed [2*SAMPLE_W-1:0] product;

   // Stage is free when empty or when its item moves on this cycle.
   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_frame = frame_ff;

   always_comb begin
      sum_wide = {left_sample[SAMPLE_W-1], left_sample}
               + {right_sample[SAMPLE_W-1], right_sample};
      // The top two bits differ only when the sum left the 16-bit range.
      if (sum_wide[SAMPLE_W] != sum_wide[SAMPLE_W-1]) begin
         mono = sum_wide[SAMPLE_W] ? SAMPLE_MIN : SAMPLE_MAX;
      end else begin
         mono = sum_wide[SAMPLE_W-1:0];
      end
      product = mono * mono;

      frame_in.begin_capture = begin_capture;
      frame_in.mono_sample   = mono;
      frame_in.square        = product[SQUARE_W-1:0];

      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         frame_ff <= frame_in;
      end
   end

endmodule

>>> rtl/scv_track.sv
`timescale 1ns / 1ps

module scv_track import scv_pkg::*; #(
   parameter int CHUNK_LEN  = CHUNK_LEN_DEFAULT,
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  scv_frame_type  in_frame,
   input  scv_cfg_type    cfg,
   output logic           out_valid,
   input  logic           out_ready,
   output scv_result_type out_result
);

   localparam int CHUNK_BITS = (CHUNK_LEN > 1) ? $clog2(CHUNK_LEN) : 1;
   localparam int CMP_BITS   = ((COUNT_BITS > CNT_FIELD_W) ? COUNT_BITS : CNT_FIELD_W) + 1;
   localparam logic [CHUNK_BITS-1:0] CHUNK_LAST = CHUNK_BITS'(CHUNK_LEN - 1);

   logic                  recording_ff, recording_in;
   logic                  seen_ff, seen_in;
   logic [COUNT_BITS-1:0] stored_ff, stored_in;
   logic [COUNT_BITS-1:0] elapsed_ff, elapsed_in;
   logic [COUNT_BITS-1:0] last_ff, last_in;
   logic [CHUNK_BITS-1:0] fic_ff, fic_in;
   logic [ENERGY_W-1:0]   energy_ff, energy_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   scv_result_type        result_ff, result_in;

   logic                  take;
   logic                  run;
   logic                  seen0;
   logic [COUNT_BITS-1:0] stored0, elapsed0, last0;
   logic [CHUNK_BITS-1:0] fic0;
   logic [ENERGY_W-1:0]   energy0, energy1;
   logic [ENERGY_W:0]     energy_add;
   logic                  store_ok, c_end, loud, stop, stop_timeout;
   logic [COUNT_BITS-1:0] stored1, elapsed1;
   logic [CMP_BITS-1:0]   c_stored0, c_stored1, c_elapsed1, c_last0;
   logic [CMP_BITS-1:0]   diff_quiet, end_quiet, kept_quiet, kept_c;

   assign in_ready   = !rsp_valid_ff || out_ready;
   assign take       = in_valid && in_ready;
   assign out_valid  = rsp_valid_ff;
   assign out_result = result_ff;

   always_comb begin
      run = in_frame.begin_capture || recording_ff;

      // A new capture starts from cleared state within this same item.
      if (in_frame.begin_capture) begin
         seen0    = 1'b0;
         stored0  = '0;
         elapsed0 = '0;
         last0    = '0;
         fic0     = '0;
         energy0  = '0;
      end else begin
         seen0    = seen_ff;
         stored0  = stored_ff;
         elapsed0 = elapsed_ff;
         last0    = last_ff;
         fic0     = fic_ff;
         energy0  = energy_ff;
      end

      c_stored0 = CMP_BITS'(stored0);
      store_ok  = (c_stored0 < CMP_BITS'(cfg.buffer_capacity))
                && (stored0 != {COUNT_BITS{1'b1}});
      stored1   = stored0 + COUNT_BITS'(store_ok);
      elapsed1  = elapsed0 + COUNT_BITS'(elapsed0 != {COUNT_BITS{1'b1}});

      energy_add = {1'b0, energy0} + (ENERGY_W + 1)'(in_frame.square);
      energy1    = energy_add[ENERGY_W] ? {ENERGY_W{1'b1}} : energy_add[ENERGY_W-1:0];

      c_end = (fic0 == CHUNK_LAST);
      loud  = energy1 > {1'b0, cfg.energy_threshold};

      c_stored1  = CMP_BITS'(stored1);
      c_elapsed1 = CMP_BITS'(elapsed1);
      c_last0    = CMP_BITS'(last0);

      // Both outcomes of the loudness test are prepared side by side; a loud
      // chunk moves the voice point to the current count, so its silence
      // run is zero and its trimmed end can never fall short of the count.
      diff_quiet = c_stored1 - c_last0;
      end_quiet  = c_last0 + CMP_BITS'(cfg.trail_pad);
      kept_quiet = (end_quiet > c_stored1) ? c_stored1 : end_quiet;
      kept_c     = loud ? c_stored1 : kept_quiet;

      if (loud) begin
         stop_timeout = (cfg.silence_timeout == '0);
      end else if (seen0) begin
         stop_timeout = diff_quiet >= CMP_BITS'(cfg.silence_timeout);
      end else begin
         stop_timeout = c_elapsed1 > CMP_BITS'(cfg.no_speech_timeout);
      end
      stop = stop_timeout
           || (c_elapsed1 > CMP_BITS'(cfg.max_record))
           || (c_stored1 >= CMP_BITS'(cfg.buffer_capacity));

      result_in.mono_sample  = in_frame.mono_sample;
      result_in.store_enable = run && store_ok;
      result_in.store_index  = (run && store_ok) ? c_stored0[CNT_FIELD_W-1:0] : '0;
      result_in.chunk_end    = run && c_end;
      result_in.chunk_loud   = run && c_end && loud;
      result_in.capture_done = run && c_end && stop;
      result_in.speech_found = run && c_end && stop && (seen0 || loud);
      result_in.kept_length  = (run && c_end && stop && (seen0 || loud))
                             ? kept_c[CNT_FIELD_W-1:0] : '0;

      recording_in = recording_ff;
      seen_in      = seen_ff;
      stored_in    = stored_ff;
      elapsed_in   = elapsed_ff;
      last_in      = last_ff;
      fic_in       = fic_ff;
      energy_in    = energy_ff;
      if (take && run) begin
         recording_in = !(c_end && stop);
         stored_in    = stored1;
         elapsed_in   = elapsed1;
         if (c_end) begin
            seen_in   = seen0 || loud;
            last_in   = loud ? stored1 : last0;
            fic_in    = '0;
            energy_in = '0;
         end else begin
            seen_in   = seen0;
            last_in   = last0;
            fic_in    = fic0 + CHUNK_BITS'(1);
            energy_in = energy1;
         end
      end

      rsp_valid_in = in_ready ? in_valid : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         recording_ff <= 1'b0;
         seen_ff      <= 1'b0;
         stored_ff    <= '0;
         elapsed_ff   <= '0;
         last_ff      <= '0;
         fic_ff       <= '0;
         energy_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         recording_ff <= recording_in;
         seen_ff      <= seen_in;
         stored_ff    <= stored_in;
         elapsed_ff   <= elapsed_in;
         last_ff      <= last_in;
         fic_ff       <= fic_in;
         energy_ff    <= energy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         result_ff <= result_in;
      end
   end

endmodule

>>> rtl/speech_capture_vad_core.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Contents
// req_      in         req_tvalid/req_tready  one stereo frame and a start flag
// rsp_      out        rsp_tvalid/rsp_tready  one result item for every frame
// csr_      in         csr_valid/csr_ready    register index and write data
//
// Every frame passes through two registers on its way to a result: one after
// the mono sum and its square, one after the capture tracking and chunk test.
// A new frame is taken in every cycle while results are being drained.
// Reset is synchronous and active high; it clears the capture state and
// loads the register defaults. A stall on the result side holds the result
// stage; once both stages hold an item, req_tready drops in the same cycle.
module speech_capture_vad_core import scv_pkg::*; #(
   parameter int CHUNK_LEN  = CHUNK_LEN_DEFAULT,
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [15:0] left_sample, [31:16] right_sample
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // [0] begin_capture
   input  logic [REQ_TUSER_W-1:0] req_tuser,

   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [15:0] mono_sample, [39:16] store_index, [63:40] kept_length
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // [0] store_enable, [1] chunk_end, [2] chunk_loud, [3] speech_found
   output logic [RSP_TUSER_W-1:0] rsp_tuser,
   // capture_done: the recording ended with this item
   output logic                   rsp_tlast,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   scv_cfg_type    cfg;
   scv_frame_type  frame;
   scv_result_type result;
   logic           frame_valid;
   logic           frame_ready;

   // Register file: write only with no capture item in flight; not enforced.
   scv_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // First stage: saturating stereo-to-mono sum and its square. Neither
   // depends on capture state, so it is done ahead of the tracking stage.
   scv_front u_front (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .begin_capture (req_tuser[0]),
      .left_sample   (req_tdata[SAMPLE_W-1:0]),
      .right_sample  (req_tdata[2*SAMPLE_W-1:SAMPLE_W]),
      .out_valid     (frame_valid),
      .out_ready     (frame_ready),
      .out_frame     (frame)
   );

   // Second stage: storage index, chunk energy, speech and stop decisions,
   // and the result register that faces the output channel.
   scv_track #(
      .CHUNK_LEN  (CHUNK_LEN),
      .COUNT_BITS (COUNT_BITS)
   ) u_track (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (frame_valid),
      .in_ready   (frame_ready),
      .in_frame   (frame),
      .cfg        (cfg),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (result)
   );

   assign rsp_tdata = {result.kept_length, result.store_index, result.mono_sample};
   assign rsp_tuser = {result.speech_found, result.chunk_loud,
                       result.chunk_end, result.store_enable};
   assign rsp_tlast = result.capture_done;

endmodule

>>> rtl/scv_checker.sv
`timescale 1ns / 1ps

module scv_checker import scv_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic [RSP_TUSER_W-1:0] rsp_tuser,
   input logic                   rsp_tlast
);

   // A stalled result keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // Loudness is only reported on a chunk boundary.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] |-> rsp_tuser[1])
      else $error("chunk_loud without chunk_end");

   // A capture can only end on a chunk boundary.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser[1])
      else $error("capture_done without chunk_end");

   // A trimmed length is only given for a capture that found speech.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[63:40] != '0) |-> rsp_tuser[3] && rsp_tlast)
      else $error("kept_length without speech_found");

endmodule

bind speech_capture_vad_core scv_checker u_scv_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
